### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int REQ_PRI_W = 8;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_REMOVED  = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
    } spq_cmd_t;

endpackage

### src/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue kept as a sorted row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op, value and priority_req with start high; the
//   transaction is taken at a clock edge where busy is low. op selects insert
//   or remove of the front entry. Lower priority numbers leave first; equal
//   priorities leave in arrival order.
//   Result channel: done is high for exactly one cycle with status, out_value
//   and fill_count valid. The receiver cannot stall; the fields hold only
//   until the next transaction executes.
//   Timing: the accepting edge loads the operand registers and enters the
//   execute state; done and the result registers load as it ends. Only one
//   transaction is in flight: busy covers the execute state, in which every
//   cell compares against the new priority and shifts in parallel.
//   A new command may be accepted in the same cycle its predecessor's result
//   is shown.
//   Reset: rst_n clears the controller and the entry count; the queue starts
//   empty. Entry storage is not cleared and is read only below the count.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic signed [spq_pkg::VALUE_W-1:0]  value,
    input  logic [spq_pkg::REQ_PRI_W-1:0]       priority_req,
    output logic                                done,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
    output logic [spq_pkg::FILL_W-1:0]          fill_count
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    spq_datapath #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (op),
        .value        (value),
        .priority_req (priority_req),
        .status       (status),
        .out_value    (out_value),
        .fill_count   (fill_count)
    );

endmodule

### src/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted row of entry cells with operand and result registers.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::spq_cmd_t                   cmd,
    input  logic                                op,
    input  logic signed [spq_pkg::VALUE_W-1:0]  value,
    input  logic [spq_pkg::REQ_PRI_W-1:0]       priority_req,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
    output logic [spq_pkg::FILL_W-1:0]          fill_count
);
    import spq_pkg::*;

    localparam int PB = (PRIORITY_BITS < REQ_PRI_W) ? PRIORITY_BITS : REQ_PRI_W;
    localparam int CW = $clog2(DEPTH + 1);

    logic                       op_reg;
    logic signed [VALUE_W-1:0]  val_reg;
    logic [PB-1:0]              pri_reg;

    logic signed [VALUE_W-1:0]  cell_val_reg [DEPTH];
    logic [PB-1:0]              cell_pri_reg [DEPTH];
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;

    status_t                    status_reg;
    status_t                    status_next;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic signed [VALUE_W-1:0]  out_value_next;

    logic [DEPTH-1:0]           ge;
    logic                       is_full;
    logic                       is_empty;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // ge[i]: cell i sits at or behind the insert position
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = ((count_reg > CW'(i)) && (cell_pri_reg[i] > pri_reg)) ||
                    (count_reg == CW'(i));
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        status_next    = STATUS_INSERTED;
        out_value_next = '0;
        if (op_reg == OP_INSERT)
        begin
            if (is_full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                status_next    = STATUS_REMOVED;
                out_value_next = cell_val_reg[0];
                count_next     = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            val_reg <= value;
            pri_reg <= priority_req[PB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            if (op_reg == OP_INSERT)
            begin
                if (!is_full)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (ge[i])
                        begin
                            if (i > 0 && ge[(i > 0) ? i - 1 : 0])
                            begin
                                cell_val_reg[i] <= cell_val_reg[(i > 0) ? i - 1 : 0];
                                cell_pri_reg[i] <= cell_pri_reg[(i > 0) ? i - 1 : 0];
                            end
                            else
                            begin
                                cell_val_reg[i] <= val_reg;
                                cell_pri_reg[i] <= pri_reg;
                            end
                        end
                    end
                end
            end
            else
            begin
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    cell_val_reg[i] <= cell_val_reg[i + 1];
                    cell_pri_reg[i] <= cell_pri_reg[i + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status     = status_reg;
    assign out_value  = out_value_reg;
    assign fill_count = FILL_W'(count_reg);

endmodule

### src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Transaction sequencer: accepts a command, runs it, strobes the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the transaction timing and result fields.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [spq_pkg::STATUS_W-1:0]        status,
    input logic signed [spq_pkg::VALUE_W-1:0]  out_value,
    input logic [spq_pkg::FILL_W-1:0]          fill_count
);
    import spq_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute cycle not followed by result strobe");

    a_done_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STATUS_REMOVED) |-> out_value == '0)
        else $error("out_value nonzero without a removal");

    a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fill_count) |-> done)
        else $error("fill_count changed outside a result");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .out_value  (out_value),
    .fill_count (fill_count)
);

### verif/stable_priority_queue_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top_test
// Self-checking bench for the stable priority queue. Commands go in through
// the start/busy handshake in bursts with random gaps. A scoreboard keeps its
// own sorted copy of the queue, predicts status, removed value and fill count
// for every accepted transaction, and checks each done strobe in order.
// Directed transactions cover empty remove, fill to full, dropped inserts,
// field extremes and equal priorities. Random transactions then swing the
// fill level between empty and full.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_test;
    import spq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int RANDOM_ITEMS  = 600;
    localparam int STALL_LIMIT   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam logic [REQ_PRI_W-1:0] PRIO_MASK =
        REQ_PRI_W'((64'd1 << PRIORITY_BITS) - 64'd1);

    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] out_value;
        logic [FILL_W-1:0]         fill;
    } response_t;

    class queue_scoreboard;
        logic signed [VALUE_W-1:0] held_value [DEPTH];
        logic [REQ_PRI_W-1:0]      held_prio  [DEPTH];
        int                        held_count;
        response_t                 pending_results [$];
        int                        mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        function void note_command(logic cmd_op, logic signed [VALUE_W-1:0] cmd_value,
                                   logic [REQ_PRI_W-1:0] cmd_prio);
            response_t            r;
            int                   pos;
            logic [REQ_PRI_W-1:0] p;
            p           = cmd_prio & PRIO_MASK;
            r.out_value = '0;
            if (cmd_op == OP_INSERT)
            begin
                if (held_count >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_count && held_prio[pos] <= p)
                        pos++;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_value[i] = held_value[i-1];
                        held_prio[i]  = held_prio[i-1];
                    end
                    held_value[pos] = cmd_value;
                    held_prio[pos]  = p;
                    held_count++;
                    r.status = STATUS_INSERTED;
                end
            end
            else if (held_count == 0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                r.out_value = held_value[0];
                for (int i = 1; i < held_count; i++)
                begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1]  = held_prio[i];
                end
                held_count--;
                r.status = STATUS_REMOVED;
            end
            r.fill = FILL_W'(held_count);
            pending_results.push_back(r);
        endfunction

        function void check_response(status_t got_status, logic signed [VALUE_W-1:0] got_value,
                                     logic [FILL_W-1:0] got_fill);
            response_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result status=%0d value=%0d fill=%0d",
                             $realtime, got_status, got_value, got_fill);
                return;
            end
            want = pending_results.pop_front();
            if (got_status !== want.status || got_value !== want.out_value ||
                got_fill !== want.fill)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch exp status=%0d value=%0d fill=%0d, got status=%0d value=%0d fill=%0d",
                             $realtime, want.status, want.out_value, want.fill,
                             got_status, got_value, got_fill);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        op;
    logic signed [VALUE_W-1:0]   value;
    logic [REQ_PRI_W-1:0]        priority_req;
    logic                        done;
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_W-1:0]   out_value;
    logic [FILL_W-1:0]           fill_count;

    queue_scoreboard sb = new();
    int              stall_cycles;
    int              burst_left;

    stable_priority_queue_top #(
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .value        (value),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .out_value    (out_value),
        .fill_count   (fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_response(status_t'(status), out_value, fill_count);
            if (start && !busy)
                sb.note_command(op, value, priority_req);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_command(input logic cmd_op, input logic signed [VALUE_W-1:0] cmd_value,
                                input logic [REQ_PRI_W-1:0] cmd_prio);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if ($urandom_range(3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        op           <= cmd_op;
        value        <= cmd_value;
        priority_req <= cmd_prio;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    initial
    begin
        logic signed [VALUE_W-1:0] v;
        logic [REQ_PRI_W-1:0]      p;
        int                        fill_bias;

        stall_cycles = 0;
        burst_left   = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        op           <= OP_INSERT;
        value        <= '0;
        priority_req <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty remove, fill to full with extremes and ties, dropped inserts
        send_command(OP_REMOVE, 32'sh1234_5678, 8'hFF);
        for (int k = 0; k < DEPTH; k++)
        begin
            case (k % 4)
                0: p = 8'h00;
                1: p = 8'hFF;
                default: p = 8'h07;
            endcase
            if (k == 0)
                v = 32'sh7FFF_FFFF;
            else if (k == 1)
                v = 32'sh8000_0000;
            else if (k == 2)
                v = -32'sd1;
            else
                v = VALUE_W'(k) ^ 32'hA5A5_0000;
            send_command(OP_INSERT, v, p);
        end
        send_command(OP_INSERT, 32'sh8000_0000, 8'h00);
        send_command(OP_INSERT, 32'sh7FFF_FFFF, 8'hFF);
        repeat (6) send_command(OP_REMOVE, '0, '0);

        fill_bias = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(3))
                    0: fill_bias = 15;
                    1: fill_bias = 50;
                    2: fill_bias = 85;
                    default: fill_bias = 97;
                endcase
            end
            case ($urandom_range(3))
                0: p = REQ_PRI_W'($urandom_range(255));
                1: p = REQ_PRI_W'($urandom_range(3));
                2: p = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                default: p = REQ_PRI_W'($urandom_range(8, 15));
            endcase
            v = $urandom;
            if ($urandom_range(15) == 0)
                v = ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            send_command(($urandom_range(99) < fill_bias) ? OP_INSERT : OP_REMOVE, v, p);
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
